// ===== rtl/kmst_pkg.sv =====
package kmst_pkg;

    localparam int MAX_EDGES    = 1024;
    localparam int MAX_VERTICES = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int VERT_BITS    = 6;
    localparam int VCNT_BITS    = 7;
    localparam int LABEL_BITS   = 7;
    localparam int EADDR_BITS   = $clog2(MAX_EDGES);
    localparam int ECNT_BITS    = $clog2(MAX_EDGES + 1);

    typedef struct packed {
        logic [VERT_BITS-1:0]          a;
        logic [VERT_BITS-1:0]          b;
        logic signed [WEIGHT_BITS-1:0] w;
    } edge_t;

    typedef struct packed {
        logic  done;
        logic  found;
        edge_t item;
    } sel_status_t;

    typedef struct packed {
        logic ready;
        logic done;
        logic merged;
    } un_status_t;

endpackage

// ===== rtl/kmst_select.sv =====
module kmst_select (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [kmst_pkg::EADDR_BITS-1:0]  wr_addr,
    input  kmst_pkg::edge_t                  wr_data,
    input  logic                             pass_start,
    input  logic                             first_pass,
    input  logic [kmst_pkg::ECNT_BITS-1:0]   edge_cnt,
    output kmst_pkg::sel_status_t            status
);

    kmst_pkg::edge_t mem [kmst_pkg::MAX_EDGES];

    logic                                   scan_reg;
    logic [kmst_pkg::ECNT_BITS-1:0]         idx_reg;
    logic                                   rd_vld_reg;
    logic [kmst_pkg::EADDR_BITS-1:0]        rd_idx_reg;
    kmst_pkg::edge_t                        rd_data_reg;
    logic                                   best_vld_reg;
    kmst_pkg::edge_t                        best_reg;
    logic [kmst_pkg::EADDR_BITS-1:0]        best_idx_reg;
    logic                                   prev_vld_reg;
    logic signed [kmst_pkg::WEIGHT_BITS-1:0] prev_w_reg;
    logic [kmst_pkg::EADDR_BITS-1:0]        prev_idx_reg;

    logic issue;
    logic pass_end;
    logic after_prev;
    logic before_best;
    logic take;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg[kmst_pkg::EADDR_BITS-1:0]];
    end

    // Key is (weight, store index); each pass finds the smallest key above the last one.
    always_comb
    begin
        issue       = scan_reg && (idx_reg < edge_cnt);
        pass_end    = scan_reg && !issue && !rd_vld_reg;
        after_prev  = !prev_vld_reg
                      || ($signed(rd_data_reg.w) > prev_w_reg)
                      || (($signed(rd_data_reg.w) == prev_w_reg) && (rd_idx_reg > prev_idx_reg));
        before_best = !best_vld_reg || ($signed(rd_data_reg.w) < $signed(best_reg.w));
        take        = rd_vld_reg && after_prev && before_best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= 1'b0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            best_vld_reg <= 1'b0;
            best_reg     <= '0;
            best_idx_reg <= '0;
            prev_vld_reg <= 1'b0;
            prev_w_reg   <= '0;
            prev_idx_reg <= '0;
        end
        else if (pass_start)
        begin
            scan_reg     <= 1'b1;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            if (first_pass)
            begin
                prev_vld_reg <= 1'b0;
            end
            else if (pass_end && best_vld_reg)
            begin
                // Restart right at the end of a pass: still advance past this edge.
                prev_vld_reg <= 1'b1;
                prev_w_reg   <= best_reg.w;
                prev_idx_reg <= best_idx_reg;
            end
        end
        else
        begin
            rd_vld_reg <= issue;
            rd_idx_reg <= idx_reg[kmst_pkg::EADDR_BITS-1:0];
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (take)
            begin
                best_vld_reg <= 1'b1;
                best_reg     <= rd_data_reg;
                best_idx_reg <= rd_idx_reg;
            end
            if (pass_end)
            begin
                scan_reg <= 1'b0;
                if (best_vld_reg)
                begin
                    prev_vld_reg <= 1'b1;
                    prev_w_reg   <= best_reg.w;
                    prev_idx_reg <= best_idx_reg;
                end
            end
        end
    end

    assign status.done  = pass_end;
    assign status.found = best_vld_reg;
    assign status.item  = best_reg;

endmodule

// ===== rtl/kmst_union.sv =====
module kmst_union (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            init_start,
    input  logic                            check_start,
    input  logic [kmst_pkg::VCNT_BITS-1:0]  n,
    input  logic [kmst_pkg::VERT_BITS-1:0]  va,
    input  logic [kmst_pkg::VERT_BITS-1:0]  vb,
    output kmst_pkg::un_status_t            status
);

    typedef enum logic [2:0] {
        U_IDLE,
        U_INIT,
        U_LOOK_A,
        U_LOOK_B,
        U_LOOK_C,
        U_SWEEP
    } ustate_t;

    logic [kmst_pkg::LABEL_BITS-1:0] labels [kmst_pkg::MAX_VERTICES];

    ustate_t                          state_reg;
    logic [kmst_pkg::VCNT_BITS-1:0]   v_reg;
    logic                             rs_vld_reg;
    logic [kmst_pkg::VERT_BITS-1:0]   rs_idx_reg;
    logic [kmst_pkg::LABEL_BITS-1:0]  la_reg;
    logic [kmst_pkg::LABEL_BITS-1:0]  lb_reg;
    logic [kmst_pkg::LABEL_BITS-1:0]  next_label_reg;
    logic [kmst_pkg::LABEL_BITS-1:0]  rd_data_reg;

    logic                             wr_en;
    logic [kmst_pkg::VERT_BITS-1:0]   wr_addr;
    logic [kmst_pkg::LABEL_BITS-1:0]  wr_data;
    logic [kmst_pkg::VERT_BITS-1:0]   rd_addr;
    logic                             issue;
    logic                             sweep_end;
    logic                             same;

    always_comb
    begin
        issue     = (state_reg == U_SWEEP) && (v_reg < n);
        sweep_end = (state_reg == U_SWEEP) && !issue && !rs_vld_reg;
        same      = (rd_data_reg == la_reg);
        wr_en     = 1'b0;
        wr_addr   = v_reg[kmst_pkg::VERT_BITS-1:0];
        wr_data   = kmst_pkg::LABEL_BITS'(v_reg);
        case (state_reg)
            U_LOOK_A: rd_addr = va;
            U_LOOK_B: rd_addr = vb;
            default:  rd_addr = v_reg[kmst_pkg::VERT_BITS-1:0];
        endcase
        if (state_reg == U_INIT)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == U_SWEEP && rs_vld_reg
                 && (rd_data_reg == la_reg || rd_data_reg == lb_reg))
        begin
            // Relabel both merged sets with the fresh label.
            wr_en   = 1'b1;
            wr_addr = rs_idx_reg;
            wr_data = next_label_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            labels[wr_addr] <= wr_data;
        end
        rd_data_reg <= labels[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= U_IDLE;
            v_reg          <= '0;
            rs_vld_reg     <= 1'b0;
            rs_idx_reg     <= '0;
            la_reg         <= '0;
            lb_reg         <= '0;
            next_label_reg <= '0;
        end
        else
        begin
            case (state_reg)
                U_IDLE:
                begin
                    if (init_start)
                    begin
                        v_reg          <= '0;
                        next_label_reg <= n;
                        state_reg      <= U_INIT;
                    end
                    else if (check_start)
                    begin
                        state_reg <= U_LOOK_A;
                    end
                end
                U_INIT:
                begin
                    v_reg <= v_reg + 1'b1;
                    if (v_reg == kmst_pkg::VCNT_BITS'(kmst_pkg::MAX_VERTICES - 1))
                    begin
                        state_reg <= U_IDLE;
                    end
                end
                U_LOOK_A:
                begin
                    state_reg <= U_LOOK_B;
                end
                U_LOOK_B:
                begin
                    la_reg    <= rd_data_reg;
                    state_reg <= U_LOOK_C;
                end
                U_LOOK_C:
                begin
                    if (same)
                    begin
                        state_reg <= U_IDLE;
                    end
                    else
                    begin
                        lb_reg     <= rd_data_reg;
                        v_reg      <= '0;
                        rs_vld_reg <= 1'b0;
                        state_reg  <= U_SWEEP;
                    end
                end
                U_SWEEP:
                begin
                    rs_vld_reg <= issue;
                    rs_idx_reg <= v_reg[kmst_pkg::VERT_BITS-1:0];
                    if (issue)
                    begin
                        v_reg <= v_reg + 1'b1;
                    end
                    if (sweep_end)
                    begin
                        next_label_reg <= next_label_reg + 1'b1;
                        state_reg      <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign status.ready  = (state_reg == U_IDLE);
    assign status.done   = ((state_reg == U_LOOK_C) && same) || sweep_end;
    assign status.merged = sweep_end;

endmodule

// ===== rtl/kruskal_min_spanning_tree_unit.sv =====
// Minimum spanning tree engine. Edges load one per cycle while busy is low; the
// edge flagged last_edge starts the tree build and raises busy until the final
// result has been sent. The build clears 64 set labels, then, for each edge in
// ascending weight order (ties in load order), scans the whole edge store
// through its single read port and runs a label lookup and, if the ends lie in
// different sets, a relabel sweep over the vertices. The build stops early once
// n - 1 tree edges are found. Results come out with result_valid, with no way to
// stall them; the receiver must take every transaction. The last result has
// last_result set; an empty tree gives one result with edge_present low.
// overflow reports any edge dropped for a full store or a vertex beyond
// vertex_count.
module kruskal_min_spanning_tree_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [kmst_pkg::VERT_BITS-1:0]        first_vertex,
    input  logic [kmst_pkg::VERT_BITS-1:0]        second_vertex,
    input  logic signed [kmst_pkg::WEIGHT_BITS-1:0] edge_weight,
    input  logic                                  last_edge,
    output logic                                  result_valid,
    output logic                                  edge_present,
    output logic [kmst_pkg::VERT_BITS-1:0]        tree_first_vertex,
    output logic [kmst_pkg::VERT_BITS-1:0]        tree_second_vertex,
    output logic signed [kmst_pkg::WEIGHT_BITS-1:0] tree_weight,
    output logic                                  overflow,
    output logic                                  last_result
);

    typedef enum logic [2:0] {
        T_LOAD,
        T_INIT,
        T_WAIT_INIT,
        T_SCAN,
        T_UNION,
        T_FINISH
    } tstate_t;

    tstate_t                          state_reg;
    tstate_t                          state_next;
    logic [kmst_pkg::VCNT_BITS-1:0]   vcount_reg;
    logic [kmst_pkg::ECNT_BITS-1:0]   cnt_reg;
    logic                             dropped_reg;
    logic [kmst_pkg::VERT_BITS-1:0]   acc_reg;
    logic                             pend_vld_reg;
    kmst_pkg::edge_t                  pend_reg;

    logic [kmst_pkg::VCNT_BITS-1:0]   n;
    logic                             accept;
    logic                             in_ok;
    logic                             wr_en;
    logic                             pass_go;
    logic                             first_go;
    logic                             init_go;
    logic                             check_go;
    logic                             add_edge;
    logic                             sel_in_range;
    logic                             cfg_wr;
    kmst_pkg::edge_t                  wr_data;
    kmst_pkg::sel_status_t            sel_st;
    kmst_pkg::un_status_t             un_st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {25'b0, vcount_reg} : 32'b0;
    assign busy   = (state_reg != T_LOAD);

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n = kmst_pkg::VCNT_BITS'(1);
        end
        else if (vcount_reg > kmst_pkg::VCNT_BITS'(kmst_pkg::MAX_VERTICES))
        begin
            n = kmst_pkg::VCNT_BITS'(kmst_pkg::MAX_VERTICES);
        end
        else
        begin
            n = vcount_reg;
        end
    end

    always_comb
    begin
        accept       = start && !busy;
        in_ok        = ({1'b0, first_vertex} < n) && ({1'b0, second_vertex} < n)
                       && (cnt_reg < kmst_pkg::ECNT_BITS'(kmst_pkg::MAX_EDGES));
        wr_en        = accept && in_ok;
        wr_data.a    = first_vertex;
        wr_data.b    = second_vertex;
        wr_data.w    = edge_weight;
        sel_in_range = ({1'b0, sel_st.item.a} < n) && ({1'b0, sel_st.item.b} < n);
        state_next   = state_reg;
        pass_go      = 1'b0;
        first_go     = 1'b0;
        init_go      = 1'b0;
        check_go     = 1'b0;
        add_edge     = 1'b0;
        case (state_reg)
            T_LOAD:
            begin
                if (accept && last_edge)
                begin
                    state_next = T_INIT;
                end
            end
            T_INIT:
            begin
                init_go    = 1'b1;
                state_next = T_WAIT_INIT;
            end
            T_WAIT_INIT:
            begin
                if (un_st.ready)
                begin
                    pass_go    = 1'b1;
                    first_go   = 1'b1;
                    state_next = T_SCAN;
                end
            end
            T_SCAN:
            begin
                if (sel_st.done)
                begin
                    if (!sel_st.found)
                    begin
                        state_next = T_FINISH;
                    end
                    else if (!sel_in_range)
                    begin
                        // Skip edges left stale by a lowered vertex count.
                        pass_go = 1'b1;
                    end
                    else
                    begin
                        check_go   = 1'b1;
                        state_next = T_UNION;
                    end
                end
            end
            T_UNION:
            begin
                if (un_st.done)
                begin
                    add_edge = un_st.merged;
                    if (un_st.merged
                        && ({1'b0, acc_reg} + 1'b1 == n - 1'b1))
                    begin
                        state_next = T_FINISH;
                    end
                    else
                    begin
                        pass_go    = 1'b1;
                        state_next = T_SCAN;
                    end
                end
            end
            T_FINISH:
            begin
                state_next = T_LOAD;
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= T_LOAD;
            vcount_reg         <= kmst_pkg::VCNT_BITS'(kmst_pkg::MAX_VERTICES);
            cnt_reg            <= '0;
            dropped_reg        <= 1'b0;
            acc_reg            <= '0;
            pend_vld_reg       <= 1'b0;
            pend_reg           <= '0;
            result_valid       <= 1'b0;
            edge_present       <= 1'b0;
            tree_first_vertex  <= '0;
            tree_second_vertex <= '0;
            tree_weight        <= '0;
            overflow           <= 1'b0;
            last_result        <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= 1'b0;
            if (cfg_wr)
            begin
                vcount_reg <= pwdata[kmst_pkg::VCNT_BITS-1:0];
            end
            if (wr_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (accept && !in_ok)
            begin
                dropped_reg <= 1'b1;
            end
            if (init_go)
            begin
                acc_reg      <= '0;
                pend_vld_reg <= 1'b0;
            end
            // Hold each tree edge back until the next is found so the final one can carry last_result.
            if (add_edge)
            begin
                acc_reg      <= acc_reg + 1'b1;
                pend_reg     <= sel_st.item;
                pend_vld_reg <= 1'b1;
                if (pend_vld_reg)
                begin
                    result_valid       <= 1'b1;
                    edge_present       <= 1'b1;
                    tree_first_vertex  <= pend_reg.a;
                    tree_second_vertex <= pend_reg.b;
                    tree_weight        <= pend_reg.w;
                    overflow           <= dropped_reg;
                    last_result        <= 1'b0;
                end
            end
            if (state_reg == T_FINISH)
            begin
                result_valid       <= 1'b1;
                edge_present       <= pend_vld_reg;
                tree_first_vertex  <= pend_vld_reg ? pend_reg.a : '0;
                tree_second_vertex <= pend_vld_reg ? pend_reg.b : '0;
                tree_weight        <= pend_vld_reg ? pend_reg.w : '0;
                overflow           <= dropped_reg;
                last_result        <= 1'b1;
                cnt_reg            <= '0;
                dropped_reg        <= 1'b0;
                pend_vld_reg       <= 1'b0;
            end
        end
    end

    kmst_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (cnt_reg[kmst_pkg::EADDR_BITS-1:0]),
        .wr_data    (wr_data),
        .pass_start (pass_go),
        .first_pass (first_go),
        .edge_cnt   (cnt_reg),
        .status     (sel_st)
    );

    kmst_union u_union (
        .clk         (clk),
        .rst_n       (rst_n),
        .init_start  (init_go),
        .check_start (check_go),
        .n           (n),
        .va          (sel_st.item.a),
        .vb          (sel_st.item.b),
        .status      (un_st)
    );

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !result_valid)
        else $error("result after last transaction");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !edge_present |-> last_result)
        else $error("empty result not marked last");

    a_last_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_edge |=> busy)
        else $error("build did not start");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic                                    present;
        logic [kmst_pkg::VERT_BITS-1:0]          a;
        logic [kmst_pkg::VERT_BITS-1:0]          b;
        logic signed [kmst_pkg::WEIGHT_BITS-1:0] w;
        logic                                    ovf;
        logic                                    last;
    } tree_res_t;

    localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic start;
    logic busy;
    logic [kmst_pkg::VERT_BITS-1:0] first_vertex, second_vertex;
    logic signed [kmst_pkg::WEIGHT_BITS-1:0] edge_weight;
    logic last_edge;
    logic result_valid;
    logic edge_present;
    logic [kmst_pkg::VERT_BITS-1:0] tree_first_vertex, tree_second_vertex;
    logic signed [kmst_pkg::WEIGHT_BITS-1:0] tree_weight;
    logic overflow;
    logic last_result;

    kruskal_min_spanning_tree_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .first_vertex(first_vertex), .second_vertex(second_vertex),
        .edge_weight(edge_weight), .last_edge(last_edge),
        .result_valid(result_valid), .edge_present(edge_present),
        .tree_first_vertex(tree_first_vertex), .tree_second_vertex(tree_second_vertex),
        .tree_weight(tree_weight), .overflow(overflow), .last_result(last_result)
    );

    // predictor state
    kmst_pkg::edge_t loaded_edges[$];
    logic            edges_dropped;
    int              vertex_count_reg;
    tree_res_t       tree_expected[$];
    int              mismatches;
    int              sender_idle_pct;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int used_vertices();
        if (vertex_count_reg < 1)
            return 1;
        if (vertex_count_reg > kmst_pkg::MAX_VERTICES)
            return kmst_pkg::MAX_VERTICES;
        return vertex_count_reg;
    endfunction

    // Store or drop one edge; on the final edge build the expected tree.
    function automatic void predict_edge(kmst_pkg::edge_t e, logic fin);
        int n;
        int j;
        int found;
        int la, lb;
        int next_lab;
        int labels[kmst_pkg::MAX_VERTICES];
        kmst_pkg::edge_t sorted[$];
        kmst_pkg::edge_t key;
        tree_res_t r;
        n = used_vertices();
        if (e.a >= n || e.b >= n || loaded_edges.size() >= kmst_pkg::MAX_EDGES)
            edges_dropped = 1'b1;
        else
            loaded_edges.push_back(e);
        if (!fin)
            return;
        sorted = loaded_edges;
        for (int i = 1; i < sorted.size(); i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1].w > key.w)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        for (int v = 0; v < kmst_pkg::MAX_VERTICES; v++)
            labels[v] = v;
        next_lab = n;
        found = 0;
        foreach (sorted[i])
        begin
            if (sorted[i].a >= n || sorted[i].b >= n)
                continue;
            la = labels[sorted[i].a];
            lb = labels[sorted[i].b];
            if (la == lb)
                continue;
            for (int v = 0; v < n; v++)
                if (labels[v] == la || labels[v] == lb)
                    labels[v] = next_lab;
            next_lab++;
            r = '{1'b1, sorted[i].a, sorted[i].b, sorted[i].w, edges_dropped, 1'b0};
            tree_expected.push_back(r);
            found++;
        end
        if (found == 0)
            tree_expected.push_back('{1'b0, '0, '0, '0, edges_dropped, 1'b1});
        else
            tree_expected[tree_expected.size()-1].last = 1'b1;
        loaded_edges.delete();
        edges_dropped = 1'b0;
    endfunction

    // Hold start high until the edge is taken; leaves start high for the next one unless it idles at random.
    task automatic send_edge(int a, int b, int w, logic fin);
        kmst_pkg::edge_t e;
        e.a = a[kmst_pkg::VERT_BITS-1:0];
        e.b = b[kmst_pkg::VERT_BITS-1:0];
        e.w = w[kmst_pkg::WEIGHT_BITS-1:0];
        start         <= 1'b1;
        first_vertex  <= e.a;
        second_vertex <= e.b;
        edge_weight   <= e.w;
        last_edge     <= fin;
        do
            @(posedge clk);
        while (busy);
        predict_edge(e, fin);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tree_expected.size() != 0 || busy);
        repeat (10) @(posedge clk);
    endtask

    // Write only once the engine is idle and every expected result has come.
    task automatic write_vertex_count(int value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_VERTEX_COUNT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vertex_count_reg = value & 127;
        @(posedge clk);
    endtask

    // One graph of random content; a few edges may carry out-of-range vertices.
    task automatic send_graph(int edges, int n, int wspan);
        int a, b, w;
        for (int i = 0; i < edges; i++)
        begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            if ($urandom_range(99) < 4)
                a = $urandom_range(63);
            if (wspan == 0)
                w = $urandom_range(16'hffff);
            else
                w = $urandom_range(wspan) - wspan / 2;
            send_edge(a, b, w, i == edges - 1);
        end
    endtask

    task automatic test_extremes();
        write_vertex_count(64);
        send_edge(0, 63, -32768, 0);
        send_edge(63, 0, 32767, 0);
        send_edge(5, 5, 0, 0);
        send_edge(1, 2, -1, 0);
        send_edge(2, 1, -1, 0);
        send_edge(42, 21, 21845, 0);
        send_edge(21, 42, -21846, 0);
        send_edge(2, 63, 0, 1);
        // self loop alone gives an empty tree
        send_edge(7, 7, 100, 1);
        drain();
    endtask

    task automatic test_vertex_range();
        write_vertex_count(4);
        send_edge(1, 10, 5, 0);
        send_edge(0, 3, 2, 0);
        send_edge(3, 1, 1, 1);
        drain();
        // lower the count while edges are loaded
        write_vertex_count(64);
        send_edge(20, 1, 3, 0);
        send_edge(0, 1, 4, 0);
        send_edge(2, 6, 1, 0);
        drain();
        write_vertex_count(8);
        send_edge(5, 6, 9, 1);
        drain();
        // zero acts as one vertex
        write_vertex_count(0);
        send_edge(0, 0, -5, 0);
        send_edge(0, 1, 3, 1);
        drain();
        write_vertex_count(127);
        send_edge(63, 62, 8, 1);
        drain();
    endtask

    task automatic test_random_phase(int idle_pct, int items);
        int sent, edges, n, pick;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(9);
            n = (pick == 0) ? 1 : (pick == 1) ? 64 : (pick == 2) ? 2 : $urandom_range(3, 64);
            write_vertex_count(n);
            edges = ($urandom_range(19) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
            send_graph(edges, n, ($urandom_range(2) == 0) ? 6 : 0);
            sent += edges;
            // wait out all results now and then
            if ($urandom_range(3) == 0)
                drain();
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        tree_res_t got, want;
        if (result_valid)
        begin
            got = '{edge_present, tree_first_vertex, tree_second_vertex, tree_weight,
                    overflow, last_result};
            if (tree_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = tree_expected.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        mismatches       = 0;
        edges_dropped    = 1'b0;
        vertex_count_reg = 64;
        sender_idle_pct  = 0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        start   <= 1'b0;
        first_vertex  <= '0;
        second_vertex <= '0;
        edge_weight   <= '0;
        last_edge     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_vertex_range();
        test_random_phase(0, 145);
        test_random_phase(71, 140);
        test_random_phase(16, 140);
        if (tree_expected.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kmst_pkg.sv
rtl/kmst_select.sv
rtl/kmst_union.sv
rtl/kruskal_min_spanning_tree_unit.sv
bench/tb.sv
